### src/bes_pkg.sv
// Package with the widths, constants, types and helpers of the bounded exponential sampler.
package bes_pkg;

   localparam int PROB_BITS = 32;
   localparam int PROB_W    = PROB_BITS + 1;
   localparam int WORD_W    = 64;
   localparam int RATE_W    = 32;
   localparam int OUT_W     = 40;
   localparam int LOG_FRAC  = 40;
   localparam int MANT_W    = 63;
   localparam int EXP_W     = 6;
   localparam int NLOG_W    = 46;
   localparam int T_W       = 37;
   localparam int LANES     = 2;
   localparam int LANE_SMP  = 0;
   localparam int LANE_MAX  = 1;

   localparam logic [63:0]       LN2_Q64    = 64'hB172_17F7_D1CF_79AB;
   localparam logic [OUT_W-1:0]  SAMPLE_MAX = '1;
   localparam logic [PROB_W-1:0] PROB_ONE   = 33'h1_0000_0000;
   localparam logic [31:0]       MAX_INPUT_RESET = 32'hFFFF_FFFF;

   // Register indexes of the configuration port.
   localparam logic REG_MAX_INPUT = 1'b0;

   // Per-word flags and operands that travel alongside the arithmetic.
   typedef struct packed {
      logic              berr;
      logic              clamped;
      logic              rate_zero;
      logic [RATE_W-1:0] rate;
   } bes_side_type;

   // Index of the most significant set bit, zero when no bit is set.
   function automatic logic [EXP_W-1:0] lead_one(input logic [PROB_W-1:0] v);
      logic [EXP_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < PROB_W; i++) begin
         if (v[i]) idx = EXP_W'(i);
      end
      return idx;
   endfunction

endpackage

### src/bounded_exponential_sampler.sv
// Top level of the bounded exponential sampler: a fully pipelined inverse-CDF exponential sampler.
//
// Each accepted word carries a 64-bit random draw, two probability bounds in Q1.32 and a rate in
// Q16.16. The draw is scaled onto a probability u between the bounds, and the block returns
// -ln(1-u)/rate in Q24.16 together with -ln(1-max_input)/rate, the largest sample the rate allows.
// When u reaches one, max_input (the only register, at byte address 0) stands in for it and the
// clamped flag is raised. A bound above one raises bound_error and gives a zero sample; a rate of
// zero saturates the maximum and, without a bound error, saturates the sample and raises saturated.
// The block takes one word every cycle while no result is held by rsp_stall. The draw is scaled
// and the two logarithm operands normalised, the forty squaring steps of the binary logarithm
// follow (each a registered multiply and a registered accumulate), then a multiply by ln 2 and
// the restoring division by the rate, one quotient bit per step, with a final output register.
// Both the sample and the maximum travel side by side in two lanes of the same pipeline. When a
// result is held by rsp_stall the whole pipeline pauses and req_stall is raised in the same cycle;
// nothing is dropped or repeated.
module bounded_exponential_sampler (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_random_word,
   input  logic [32:0] req_low_bound,
   input  logic [32:0] req_high_bound,
   input  logic [31:0] req_rate,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [39:0] rsp_sample,
   output logic [39:0] rsp_max_sample,
   output logic        rsp_clamped,
   output logic        rsp_bound_error,
   output logic        rsp_saturated,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int LANES = bes_pkg::LANES;

   // The whole pipeline advances together unless a finished result is being held.
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------- configuration
   logic [31:0] max_input_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == bes_pkg::REG_MAX_INPUT) ? max_input_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_input_ff <= bes_pkg::MAX_INPUT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == bes_pkg::REG_MAX_INPUT) begin
         max_input_ff <= csr_pwdata;
      end
   end

   // ---------------------------------------------------------------- stage 1: draw products
   // The bound distance is multiplied by the two halves of the draw.
   logic        low_over, high_over, dir_up;
   logic [32:0] span;
   assign low_over  = req_low_bound > bes_pkg::PROB_ONE;
   assign high_over = req_high_bound > bes_pkg::PROB_ONE;
   assign dir_up    = req_high_bound >= req_low_bound;
   assign span      = dir_up ? (req_high_bound - req_low_bound) : (req_low_bound - req_high_bound);

   logic                 s1_valid_ff;
   logic [64:0]          s1_plo_ff, s1_phi_ff;
   logic [32:0]          s1_low_ff, s1_vmax_ff;
   logic                 s1_up_ff;
   bes_pkg::bes_side_type s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_plo_ff  <= {32'd0, span} * {33'd0, req_random_word[31:0]};
         s1_phi_ff  <= {32'd0, span} * {33'd0, req_random_word[63:32]};
         s1_low_ff  <= req_low_bound;
         s1_up_ff   <= dir_up;
         s1_vmax_ff <= bes_pkg::PROB_ONE - {1'b0, max_input_ff};
         s1_side_ff <= '{berr: low_over || high_over, clamped: 1'b0,
                         rate_zero: req_rate == 32'd0, rate: req_rate};
      end
   end

   // ---------------------------------------------------------------- stage 2: full product
   logic [96:0] prod;
   assign prod = {32'd0, s1_plo_ff} + {s1_phi_ff, 32'd0};

   logic                 s2_valid_ff;
   logic [32:0]          s2_hi_ff, s2_low_ff, s2_vmax_ff;
   logic [63:0]          s2_lo_ff;
   logic                 s2_up_ff;
   bes_pkg::bes_side_type s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_hi_ff   <= prod[96:64];
         s2_lo_ff   <= prod[63:0];
         s2_low_ff  <= s1_low_ff;
         s2_up_ff   <= s1_up_ff;
         s2_vmax_ff <= s1_vmax_ff;
         s2_side_ff <= s1_side_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3: divide by 2^64-1
   // floor(x / (2^64-1)) is the high half, plus one when high and low halves reach 2^64-1.
   logic        round_up;
   logic [32:0] draw_q;
   assign round_up = ({32'd0, s2_hi_ff} + {1'b0, s2_lo_ff}) >= 65'h0_FFFF_FFFF_FFFF_FFFF;
   assign draw_q   = s2_hi_ff + {32'd0, round_up};

   logic                 s3_valid_ff;
   logic [32:0]          s3_q_ff, s3_low_ff, s3_vmax_ff;
   logic                 s3_up_ff;
   bes_pkg::bes_side_type s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (adv) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_q_ff    <= draw_q;
         s3_low_ff  <= s2_low_ff;
         s3_up_ff   <= s2_up_ff;
         s3_vmax_ff <= s2_vmax_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4: probability
   logic [33:0] prob_u;
   logic        is_one;
   assign prob_u = s3_up_ff ? ({1'b0, s3_low_ff} + {1'b0, s3_q_ff})
                            : ({1'b0, s3_low_ff} - {1'b0, s3_q_ff});
   assign is_one = !s3_side_ff.berr && (prob_u >= {1'b0, bes_pkg::PROB_ONE});

   logic                 s4_valid_ff;
   logic [32:0]          s4_v_ff [LANES];
   bes_pkg::bes_side_type s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (adv) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_v_ff[bes_pkg::LANE_SMP] <= is_one ? s3_vmax_ff
                                              : (bes_pkg::PROB_ONE - prob_u[32:0]);
         s4_v_ff[bes_pkg::LANE_MAX] <= s3_vmax_ff;
         s4_side_ff                 <= '{berr: s3_side_ff.berr, clamped: is_one,
                                         rate_zero: s3_side_ff.rate_zero,
                                         rate: s3_side_ff.rate};
      end
   end

   // ---------------------------------------------------------------- stage 5: normalise
   // Each lane's operand is shifted so that its top set bit lands at bit 62 (Q1.62).
   logic [bes_pkg::MANT_W-1:0]   it_m    [bes_pkg::LOG_FRAC+1][LANES];
   logic [bes_pkg::LOG_FRAC-1:0] it_frac [bes_pkg::LOG_FRAC+1][LANES];
   logic [bes_pkg::EXP_W-1:0]    it_e    [bes_pkg::LOG_FRAC+1][LANES];
   bes_pkg::bes_side_type        it_side [bes_pkg::LOG_FRAC+1];
   logic                         it_valid[bes_pkg::LOG_FRAC+1];

   logic                         s5_valid_ff;
   logic [bes_pkg::MANT_W-1:0]   s5_m_ff [LANES];
   logic [bes_pkg::EXP_W-1:0]    s5_e_ff [LANES];
   bes_pkg::bes_side_type        s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else if (adv) s5_valid_ff <= s4_valid_ff;
   end

   for (genvar l = 0; l < LANES; l++) begin : g_norm
      logic [bes_pkg::EXP_W-1:0] top;
      assign top = bes_pkg::lead_one(s4_v_ff[l]);
      always_ff @(posedge clock) begin
         if (adv) begin
            s5_m_ff[l] <= {30'd0, s4_v_ff[l]} << (6'd62 - top);
            s5_e_ff[l] <= top;
         end
      end
      assign it_m[0][l]    = s5_m_ff[l];
      assign it_e[0][l]    = s5_e_ff[l];
      assign it_frac[0][l] = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) s5_side_ff <= s4_side_ff;
   end
   assign it_side[0]  = s5_side_ff;
   assign it_valid[0] = s5_valid_ff;

   // ---------------------------------------------------------------- logarithm by squaring
   // Each step squares the mantissa; a square at or above two yields a one fraction bit and is
   // halved. The square is formed from three registered partial products and then summed.
   for (genvar k = 0; k < bes_pkg::LOG_FRAC; k++) begin : g_sq
      logic                         pv_ff, mv_ff;
      bes_pkg::bes_side_type        pside_ff, mside_ff;
      logic [61:0]                  p11_ff  [LANES];
      logic [62:0]                  p10_ff  [LANES];
      logic [63:0]                  p00_ff  [LANES];
      logic [bes_pkg::LOG_FRAC-1:0] pfrac_ff[LANES];
      logic [bes_pkg::EXP_W-1:0]    pe_ff   [LANES];
      logic [bes_pkg::MANT_W-1:0]   m_ff    [LANES];
      logic [bes_pkg::LOG_FRAC-1:0] frac_ff [LANES];
      logic [bes_pkg::EXP_W-1:0]    e_ff    [LANES];

      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff <= 1'b0;
            mv_ff <= 1'b0;
         end else if (adv) begin
            pv_ff <= it_valid[k];
            mv_ff <= pv_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            pside_ff <= it_side[k];
            mside_ff <= pside_ff;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [30:0]  a1;
         logic [31:0]  a0;
         logic [125:0] sq;
         logic [63:0]  msq;
         assign a1  = it_m[k][l][62:32];
         assign a0  = it_m[k][l][31:0];
         assign sq  = {p11_ff[l], 64'd0} + {30'd0, p10_ff[l], 33'd0} + {62'd0, p00_ff[l]};
         assign msq = sq[125:62];

         always_ff @(posedge clock) begin
            if (adv) begin
               p11_ff[l]   <= {31'd0, a1} * {31'd0, a1};
               p10_ff[l]   <= {32'd0, a1} * {31'd0, a0};
               p00_ff[l]   <= {32'd0, a0} * {32'd0, a0};
               pfrac_ff[l] <= it_frac[k][l];
               pe_ff[l]    <= it_e[k][l];
               m_ff[l]     <= msq[63] ? msq[63:1] : msq[62:0];
               frac_ff[l]  <= {pfrac_ff[l][bes_pkg::LOG_FRAC-2:0], msq[63]};
               e_ff[l]     <= pe_ff[l];
            end
         end

         assign it_m[k+1][l]    = m_ff[l];
         assign it_frac[k+1][l] = frac_ff[l];
         assign it_e[k+1][l]    = e_ff[l];
      end

      assign it_side[k+1]  = mside_ff;
      assign it_valid[k+1] = mv_ff;
   end

   // ---------------------------------------------------------------- scale by ln 2
   localparam int LF = bes_pkg::LOG_FRAC;

   logic                 l1_valid_ff, l2_valid_ff;
   bes_pkg::bes_side_type l1_side_ff, l2_side_ff;
   logic [63:0]          pp00_ff[LANES], pp01_ff[LANES];
   logic [45:0]          pp10_ff[LANES], pp11_ff[LANES];
   logic [bes_pkg::T_W-1:0] dv_num [bes_pkg::T_W+1][LANES];
   logic [31:0]          dv_rem [bes_pkg::T_W+1][LANES];
   bes_pkg::bes_side_type dv_side[bes_pkg::T_W+1];
   logic                 dv_valid[bes_pkg::T_W+1];
   logic [bes_pkg::T_W-1:0] l2_t_ff[LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_valid_ff <= 1'b0;
         l2_valid_ff <= 1'b0;
      end else if (adv) begin
         l1_valid_ff <= it_valid[LF];
         l2_valid_ff <= l1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_side_ff <= it_side[LF];
         l2_side_ff <= l1_side_ff;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_ln2
      logic [bes_pkg::NLOG_W-1:0] nlog;
      logic [109:0]               prod_ln;
      // -log2(v / 2^32) = (32 - e) - fraction, in Q.40
      assign nlog = {6'd32 - it_e[LF][l], 40'd0} - {6'd0, it_frac[LF][l]};
      // The two cross products share the weight 2^32.
      assign prod_ln = {46'd0, pp00_ff[l]}
                     + {13'd0, ({1'b0, pp01_ff[l]} + {19'd0, pp10_ff[l]}), 32'd0}
                     + {pp11_ff[l], 64'd0};

      always_ff @(posedge clock) begin
         if (adv) begin
            pp00_ff[l] <= {32'd0, nlog[31:0]} * {32'd0, bes_pkg::LN2_Q64[31:0]};
            pp01_ff[l] <= {32'd0, nlog[31:0]} * {32'd0, bes_pkg::LN2_Q64[63:32]};
            pp10_ff[l] <= {32'd0, nlog[45:32]} * {14'd0, bes_pkg::LN2_Q64[31:0]};
            pp11_ff[l] <= {32'd0, nlog[45:32]} * {14'd0, bes_pkg::LN2_Q64[63:32]};
            l2_t_ff[l] <= prod_ln[108:72];
         end
      end

      assign dv_num[0][l] = l2_t_ff[l];
      assign dv_rem[0][l] = '0;
   end

   assign dv_side[0]  = l2_side_ff;
   assign dv_valid[0] = l2_valid_ff;

   // ---------------------------------------------------------------- restoring division by rate
   // The dividend shifts out at the top while quotient bits shift in at the bottom.
   for (genvar j = 0; j < bes_pkg::T_W; j++) begin : g_div
      logic                    v_ff;
      bes_pkg::bes_side_type   side_ff;
      logic [bes_pkg::T_W-1:0] num_ff[LANES];
      logic [31:0]             rem_ff[LANES];

      always_ff @(posedge clock) begin
         if (reset) v_ff <= 1'b0;
         else if (adv) v_ff <= dv_valid[j];
      end

      always_ff @(posedge clock) begin
         if (adv) side_ff <= dv_side[j];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [32:0] trial, diff;
         logic        fits;
         assign trial = {dv_rem[j][l], dv_num[j][l][bes_pkg::T_W-1]};
         assign diff  = trial - {1'b0, dv_side[j].rate};
         assign fits  = trial >= {1'b0, dv_side[j].rate};

         always_ff @(posedge clock) begin
            if (adv) begin
               num_ff[l] <= {dv_num[j][l][bes_pkg::T_W-2:0], fits};
               rem_ff[l] <= fits ? diff[31:0] : trial[31:0];
            end
         end

         assign dv_num[j+1][l] = num_ff[l];
         assign dv_rem[j+1][l] = rem_ff[l];
      end

      assign dv_side[j+1]  = side_ff;
      assign dv_valid[j+1] = v_ff;
   end

   // ---------------------------------------------------------------- output register
   localparam int TD = bes_pkg::T_W;

   bes_pkg::bes_side_type fin_side;
   logic [bes_pkg::OUT_W-1:0] q_smp, q_max;
   assign fin_side = dv_side[TD];
   assign q_smp    = {3'd0, dv_num[TD][bes_pkg::LANE_SMP]};
   assign q_max    = {3'd0, dv_num[TD][bes_pkg::LANE_MAX]};

   logic [39:0] rsp_sample_ff, rsp_max_sample_ff;
   logic        rsp_clamped_ff, rsp_bound_error_ff, rsp_saturated_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= dv_valid[TD];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // A bound error wins over a zero rate for the sample; the maximum ignores bounds.
         if (fin_side.berr) rsp_sample_ff <= '0;
         else if (fin_side.rate_zero) rsp_sample_ff <= bes_pkg::SAMPLE_MAX;
         else rsp_sample_ff <= q_smp;
         rsp_max_sample_ff  <= fin_side.rate_zero ? bes_pkg::SAMPLE_MAX : q_max;
         rsp_clamped_ff     <= fin_side.clamped;
         rsp_bound_error_ff <= fin_side.berr;
         rsp_saturated_ff   <= !fin_side.berr && fin_side.rate_zero;
      end
   end

   assign rsp_sample      = rsp_sample_ff;
   assign rsp_max_sample  = rsp_max_sample_ff;
   assign rsp_clamped     = rsp_clamped_ff;
   assign rsp_bound_error = rsp_bound_error_ff;
   assign rsp_saturated   = rsp_saturated_ff;

   // ---------------------------------------------------------------- assertions
   // A clamped word runs the same operand as the maximum, so both results agree.
   a_clamped_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_clamped_ff |-> rsp_sample_ff == rsp_max_sample_ff)
      else $error("clamped sample differs from maximum sample");

   // A bound error gives a zero sample and no other flag.
   a_bound_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bound_error_ff
      |-> rsp_sample_ff == '0 && !rsp_clamped_ff && !rsp_saturated_ff)
      else $error("bound error result is not clean");

   // Saturation only arises from a zero rate, which also saturates the maximum.
   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_saturated_ff
      |-> rsp_sample_ff == bes_pkg::SAMPLE_MAX && rsp_max_sample_ff == bes_pkg::SAMPLE_MAX)
      else $error("saturated result not at full scale");

   // While a result is held, the pipeline must not move it.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(rsp_sample_ff) && $stable(rsp_max_sample_ff))
      else $error("held result changed");

endmodule
